@@ rtl/core/consistent_hash_ring_core_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the consistent hash ring core
// Shorthand for clocked assertions, sampled on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef CONSISTENT_HASH_RING_CORE_MACROS_SVH
`define CONSISTENT_HASH_RING_CORE_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define CHRING_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define CHRING_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CHRING_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/chring_pkg.sv @@
// ---------------------------------------------------------------------------
// Consistent hash ring package
// Beat types, ring entry type, codes and the FNV-1a fold step.
// ---------------------------------------------------------------------------
package chring_pkg;

  localparam int MAX_NODES  = 16;
  localparam int MAX_VNODES = 16;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic [3:0] node_id;
    logic [4:0] replica_count;
  } in_t;

  typedef struct packed {
    logic [3:0] node_id_out;
    logic [2:0] status;
    logic       last;
    logic [4:0] node_count;
    logic [8:0] point_count;
  } out_t;

  typedef struct packed {
    logic [31:0] hash;
    logic [3:0]  owner;
  } ent_t;

  typedef enum logic [2:0] {
    OP_BYTE   = 3'd0,
    OP_ADD    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_LOOKUP = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NONE       = 3'd1;
  localparam logic [2:0] ST_DUPLICATE  = 3'd2;
  localparam logic [2:0] ST_UNKNOWN    = 3'd3;
  localparam logic [2:0] ST_EMPTY_NAME = 3'd4;
  localparam logic [2:0] ST_FULL       = 3'd5;

  localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
  localparam logic [31:0] FNV_MULT   = 32'd16777619;
  localparam logic [7:0]  HASH_CHAR  = 8'h23;
  localparam logic [7:0]  DIGIT_ZERO = 8'h30;
  localparam logic [4:0]  MAX_WANT   = 5'd16;

  function automatic logic [31:0] chring_fold(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] prod;
    prod = (h ^ {24'd0, b}) * FNV_MULT;
    return prod;
  endfunction

endpackage

@@ rtl/core/chring_mem.sv @@
// ---------------------------------------------------------------------------
// Ring point store
// Simple dual-port memory of ring entries with a registered read port.
// ---------------------------------------------------------------------------
module chring_mem
  import chring_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  ent_t          wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output ent_t          rd_data
);

  ent_t mem_r [DEPTH];
  ent_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/consistent_hash_ring_core.sv @@
// ---------------------------------------------------------------------------
// Consistent hash ring core
// FNV-1a hashed ring of virtual node points kept sorted in one memory.
// ---------------------------------------------------------------------------
// Commands enter on in_data when start is high and busy is low. A byte beat
// folds into the hash accumulator and leaves busy low, so bytes stream one a
// cycle with no result. Add, remove, lookup and clear each return result
// beats on out_data, one cycle each, marked by out_valid; the final beat of a
// command has last set. The receiver cannot stall; results are never held.
// Add, remove and clear give one beat. Lookup gives up to replica_count beats
// (max 16), one per distinct node met along the ring from the key, else ST_NONE.
// Every pass goes through the point memory one entry per cycle. Per virtual
// point an add folds the seed character and the index digits into the key
// (the tens digit only from index ten on), scans the stored points for a
// collision (rescanning with the hash plus one after each one), shifts the
// points above the new one up one entry and inserts it, then reports. A
// remove scans once, keeping other nodes' points; a lookup scans and walks.
// The last beat comes in the cycle that busy falls; commands are sequential.
// Configuration beats on cfg_data set the virtual points per node and are
// meant for idle periods. After reset the ring is empty, the accumulator
// holds the offset basis and 4 points per node apply.
// ---------------------------------------------------------------------------
`include "consistent_hash_ring_core_macros.svh"

module consistent_hash_ring_core
  import chring_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_t        in_data,
  output logic       out_valid,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data
);

  localparam int DEPTH = MAX_NODES * MAX_VNODES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = CW + 1;
  localparam int VW    = $clog2(MAX_VNODES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SEED, S_DIG_T, S_DIG_O, S_PROBE, S_SHIFT, S_INS,
    S_REM, S_LK_SCAN, S_LK_WALK, S_LK_END, S_FIN
  } state_t;

  state_t        state_r;
  logic [31:0]   acc_r;
  logic          seen_r;
  logic [4:0]    cfg_r;
  logic [31:0]   key_r;
  logic [31:0]   h_r;
  logic [3:0]    id_r;
  logic [4:0]    want_r;
  logic [VW-1:0] vi_r;
  logic [15:0]   present_r;
  logic [4:0]    nodes_r;
  logic [CW-1:0] fill_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] lt_r;
  logic          hit_r;
  logic [CW-1:0] pos_r;
  logic [AW-1:0] wi_r;
  logic [4:0]    n_r;
  logic [15:0]   found_r;
  logic          pend_vld_r;
  logic [3:0]    pend_id_r;
  logic [2:0]    status_r;
  logic [3:0]    fin_id_r;
  logic          out_valid_r;
  out_t          out_r;
  logic          rvld_r;
  logic [AW-1:0] ridx_r;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  ent_t          wr_data;
  ent_t          rd_data;

  logic [VW-1:0] vn;
  logic [11:0]   tens_prod;
  logic [3:0]    tens;
  logic [7:0]    ones8;
  logic [31:0]   fold_h;
  logic [7:0]    fold_b;
  logic [31:0]   fold_res;
  logic [SW-1:0] room_sum;
  logic          ring_full;
  logic          scan_done;

  chring_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    if (cfg_r == 5'd0) begin
      vn = VW'(1);
    end else if (32'(cfg_r) > MAX_VNODES) begin
      vn = VW'(MAX_VNODES);
    end else begin
      vn = VW'(cfg_r);
    end
  end

  assign tens_prod = 12'(vi_r) * 12'd13;
  assign tens      = tens_prod[10:7];
  assign ones8     = 8'(vi_r) - 8'(tens) * 8'd10;

  always_comb begin
    case (state_r)
      S_SEED: begin
        fold_h = key_r;
        fold_b = HASH_CHAR;
      end
      S_DIG_T: begin
        fold_h = h_r;
        fold_b = DIGIT_ZERO + {4'd0, tens};
      end
      S_DIG_O: begin
        fold_h = h_r;
        fold_b = DIGIT_ZERO + ones8;
      end
      default: begin
        fold_h = acc_r;
        fold_b = in_data.data_byte;
      end
    endcase
  end

  assign fold_res  = chring_fold(fold_h, fold_b);
  assign room_sum  = SW'(fill_r) + SW'(vn);
  assign ring_full = (32'(nodes_r) >= MAX_NODES) || (room_sum > SW'(DEPTH));
  assign scan_done = (cnt_r == fill_r) && !rvld_r;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt_r[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = ridx_r;
    wr_data = rd_data;
    case (state_r)
      S_PROBE, S_LK_SCAN: begin
        rd_en = cnt_r < fill_r;
      end
      S_REM: begin
        rd_en   = cnt_r < fill_r;
        wr_en   = rvld_r && (rd_data.owner != id_r);
        wr_addr = lt_r[AW-1:0];
      end
      S_SHIFT: begin
        rd_en   = cnt_r > pos_r;
        rd_addr = AW'(cnt_r - 1'b1);
        wr_en   = rvld_r;
        wr_addr = ridx_r + 1'b1;
      end
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = pos_r[AW-1:0];
        wr_data = '{hash: h_r, owner: id_r};
      end
      S_LK_WALK: begin
        rd_en   = (cnt_r < fill_r) && (n_r < want_r);
        rd_addr = wi_r;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= FNV_BASIS;
      seen_r      <= 1'b0;
      cfg_r       <= 5'd4;
      present_r   <= '0;
      nodes_r     <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      rvld_r      <= 1'b0;
      pend_vld_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      rvld_r      <= rd_en;
      ridx_r      <= rd_addr;
      if (cfg_valid) begin
        cfg_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            id_r   <= in_data.node_id;
            key_r  <= acc_r;
            want_r <= (in_data.replica_count > MAX_WANT) ? MAX_WANT : in_data.replica_count;
            vi_r   <= '0;
            cnt_r  <= '0;
            lt_r   <= '0;
            hit_r  <= 1'b0;
            case (in_data.opcode)
              OP_BYTE: begin
                acc_r  <= fold_res;
                seen_r <= 1'b1;
              end
              OP_ADD: begin
                acc_r    <= FNV_BASIS;
                seen_r   <= 1'b0;
                fin_id_r <= in_data.node_id;
                if (!seen_r) begin
                  status_r <= ST_EMPTY_NAME;
                  state_r  <= S_FIN;
                end else if (present_r[in_data.node_id]) begin
                  status_r <= ST_DUPLICATE;
                  state_r  <= S_FIN;
                end else if (ring_full) begin
                  status_r <= ST_FULL;
                  state_r  <= S_FIN;
                end else begin
                  state_r <= S_SEED;
                end
              end
              OP_REMOVE: begin
                acc_r    <= FNV_BASIS;
                seen_r   <= 1'b0;
                fin_id_r <= in_data.node_id;
                if (!present_r[in_data.node_id]) begin
                  status_r <= ST_UNKNOWN;
                  state_r  <= S_FIN;
                end else begin
                  state_r <= S_REM;
                end
              end
              OP_LOOKUP: begin
                acc_r    <= FNV_BASIS;
                seen_r   <= 1'b0;
                fin_id_r <= 4'd0;
                if (fill_r == '0 || in_data.replica_count == 5'd0) begin
                  status_r <= ST_NONE;
                  state_r  <= S_FIN;
                end else begin
                  state_r <= S_LK_SCAN;
                end
              end
              OP_CLEAR: begin
                acc_r     <= FNV_BASIS;
                seen_r    <= 1'b0;
                fill_r    <= '0;
                present_r <= '0;
                nodes_r   <= '0;
                fin_id_r  <= 4'd0;
                status_r  <= ST_OK;
                state_r   <= S_FIN;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_SEED: begin
          h_r     <= fold_res;
          state_r <= (tens != 4'd0) ? S_DIG_T : S_DIG_O;
        end
        S_DIG_T: begin
          h_r     <= fold_res;
          state_r <= S_DIG_O;
        end
        S_DIG_O: begin
          h_r     <= fold_res;
          cnt_r   <= '0;
          lt_r    <= '0;
          hit_r   <= 1'b0;
          state_r <= S_PROBE;
        end
        S_PROBE: begin
          if (rd_en) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (rvld_r) begin
            if (rd_data.hash == h_r) begin
              hit_r <= 1'b1;
            end
            if (rd_data.hash < h_r) begin
              lt_r <= lt_r + 1'b1;
            end
          end
          if (scan_done) begin
            if (hit_r) begin
              h_r   <= h_r + 32'd1;
              cnt_r <= '0;
              lt_r  <= '0;
              hit_r <= 1'b0;
            end else begin
              pos_r   <= lt_r;
              cnt_r   <= fill_r;
              state_r <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          if (rd_en) begin
            cnt_r <= cnt_r - 1'b1;
          end
          if (cnt_r == pos_r && !rvld_r) begin
            state_r <= S_INS;
          end
        end
        S_INS: begin
          fill_r <= fill_r + 1'b1;
          if (vi_r == vn - 1'b1) begin
            present_r[id_r] <= 1'b1;
            nodes_r         <= nodes_r + 5'd1;
            status_r        <= ST_OK;
            state_r         <= S_FIN;
          end else begin
            vi_r    <= vi_r + 1'b1;
            state_r <= S_SEED;
          end
        end
        S_REM: begin
          if (rd_en) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (wr_en) begin
            lt_r <= lt_r + 1'b1;
          end
          if (scan_done) begin
            fill_r          <= lt_r;
            present_r[id_r] <= 1'b0;
            nodes_r         <= nodes_r - 5'd1;
            status_r        <= ST_OK;
            state_r         <= S_FIN;
          end
        end
        S_LK_SCAN: begin
          if (rd_en) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (rvld_r && rd_data.hash < key_r) begin
            lt_r <= lt_r + 1'b1;
          end
          if (scan_done) begin
            wi_r       <= (lt_r == fill_r) ? '0 : lt_r[AW-1:0];
            cnt_r      <= '0;
            n_r        <= '0;
            found_r    <= '0;
            pend_vld_r <= 1'b0;
            state_r    <= S_LK_WALK;
          end
        end
        S_LK_WALK: begin
          if (rd_en) begin
            cnt_r <= cnt_r + 1'b1;
            wi_r  <= (CW'(wi_r) + 1'b1 == fill_r) ? '0 : wi_r + 1'b1;
          end
          if (rvld_r && n_r < want_r && !found_r[rd_data.owner]) begin
            found_r[rd_data.owner] <= 1'b1;
            n_r        <= n_r + 5'd1;
            pend_id_r  <= rd_data.owner;
            pend_vld_r <= 1'b1;
            if (pend_vld_r) begin
              out_valid_r <= 1'b1;
              out_r       <= '{node_id_out: pend_id_r, status: ST_OK, last: 1'b0,
                               node_count: nodes_r, point_count: 9'(fill_r)};
            end
          end
          if ((cnt_r == fill_r || n_r >= want_r) && !rvld_r) begin
            state_r <= S_LK_END;
          end
        end
        S_LK_END: begin
          out_valid_r <= 1'b1;
          out_r       <= '{node_id_out: pend_id_r, status: ST_OK, last: 1'b1,
                           node_count: nodes_r, point_count: 9'(fill_r)};
          pend_vld_r  <= 1'b0;
          state_r     <= S_IDLE;
        end
        S_FIN: begin
          out_valid_r <= 1'b1;
          out_r       <= '{node_id_out: fin_id_r, status: status_r, last: 1'b1,
                           node_count: nodes_r, point_count: 9'(fill_r)};
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = state_r != S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `CHRING_ASSERT(a_node_count, $countones(present_r) == 32'(nodes_r), "node count mismatch")
  `CHRING_ASSERT(a_fill_bound, 32'(fill_r) <= DEPTH, "ring fill beyond store depth")
  `CHRING_IMPLY(a_out_from_work, out_valid_r, $past(state_r) != S_IDLE, "result while idle")
  `CHRING_IMPLY(a_walk_bound, state_r == S_LK_WALK, n_r <= want_r, "lookup found too many")
  `CHRING_NEXT(a_clear_empties, start && !busy && in_data.opcode == OP_CLEAR,
               fill_r == '0 && present_r == '0, "clear left points")

endmodule
